>>> rtl/core/matrix3x3_inverse_defines.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// assertion forms for the matrix inverse checker
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MI3_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// types, widths and constants of the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_W     = 32;
	localparam int N_ELEM     = 9;
	localparam int ROW_N      = 3;
	localparam int COF_W      = 2 * ELEM_W;
	localparam int HALF_W     = COF_W / 2;
	localparam int PL_W       = ELEM_W + HALF_W + 1;
	localparam int DET_W      = 98;
	localparam int REM_W      = DET_W + 1;
	localparam int QUO_W      = 32;
	localparam int THR_W      = 16;
	localparam int THR_SHIFT  = 32;
	localparam int COF_STAGES = 2;
	localparam int DET_STAGES = 5;
	localparam int DIV_STAGES = QUO_W;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic [COF_W-1:0]         mag_t;
	typedef logic [QUO_W-1:0]         quo_t;
	typedef logic [DET_W-1:0]         det_mag_t;
	typedef logic [3:0]               idx_t;

	typedef elem_t [N_ELEM-1:0] mat_t;
	typedef elem_t [ROW_N-1:0]  row_t;
	typedef cof_t  [N_ELEM-1:0] cof_vec_t;
	typedef mag_t  [N_ELEM-1:0] mag_vec_t;
	typedef quo_t  [N_ELEM-1:0] quo_vec_t;

	typedef struct packed {
		logic [N_ELEM-1:0] neg;
		logic [N_ELEM-1:0] big;
		logic              singular;
	} lane_ctl_t;

	localparam elem_t ONE_Q   = 32'sh0001_0000;
	localparam elem_t POS_MAX = 32'sh7fff_ffff;
	localparam elem_t NEG_MIN = 32'sh8000_0000;
	localparam logic [THR_W-1:0] THR_RESET = 16'd1;

	// cofactor i = m[a]*m[b] - m[c]*m[d]
	localparam idx_t COF_IDX [N_ELEM][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd7, 4'd2, 4'd8, 4'd1},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd8, 4'd0, 4'd6, 4'd2},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd6, 4'd1, 4'd7, 4'd0},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	// cofactors paired with the first row in the determinant
	localparam idx_t DET_COF [ROW_N] = '{4'd0, 4'd3, 4'd6};

endpackage

>>> rtl/core/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// two-stage pipeline: eighteen element products, then nine 2x2 cofactors
// ----------------------------------------------------------------------------
module mi3_cofactor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mi3_pkg::mat_t     in_mat,
	output logic              out_valid,
	input  logic              out_ready,
	output mi3_pkg::row_t     out_row,
	output mi3_pkg::cof_vec_t out_cof
);

	logic [mi3_pkg::COF_STAGES-1:0] v_q;
	logic [mi3_pkg::COF_STAGES:0]   rdy;

	logic signed [mi3_pkg::COF_W-1:0] prod_s1 [2*mi3_pkg::N_ELEM];
	mi3_pkg::row_t                    row_s1;
	mi3_pkg::row_t                    row_s2;
	mi3_pkg::cof_vec_t                cof_s2;

	always_comb begin
		rdy[mi3_pkg::COF_STAGES] = out_ready;
		for (int s = mi3_pkg::COF_STAGES - 1; s >= 0; s--) begin
			rdy[s] = !v_q[s] || rdy[s+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int s = 1; s < mi3_pkg::COF_STAGES; s++) begin
				if (rdy[s]) begin
					v_q[s] <= v_q[s-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			row_s1 <= in_mat[mi3_pkg::ROW_N-1:0];
			for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
				prod_s1[2*k]   <= $signed(in_mat[mi3_pkg::COF_IDX[k][0]])
					* $signed(in_mat[mi3_pkg::COF_IDX[k][1]]);
				prod_s1[2*k+1] <= $signed(in_mat[mi3_pkg::COF_IDX[k][2]])
					* $signed(in_mat[mi3_pkg::COF_IDX[k][3]]);
			end
		end
		if (rdy[1]) begin
			row_s2 <= row_s1;
			for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
				cof_s2[k] <= prod_s1[2*k] - prod_s1[2*k+1];
			end
		end
	end

	assign out_valid = v_q[mi3_pkg::COF_STAGES-1];
	assign out_row   = row_s2;
	assign out_cof   = cof_s2;

endmodule

>>> rtl/core/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// five-stage determinant pipeline: split products, term sum, magnitude,
// singular test and per-lane sign and range flags for the divider
// ----------------------------------------------------------------------------
module mi3_det (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mi3_pkg::THR_W-1:0] thr,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  mi3_pkg::row_t             in_row,
	input  mi3_pkg::cof_vec_t         in_cof,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mi3_pkg::det_mag_t         out_den,
	output mi3_pkg::mag_vec_t         out_cmag,
	output mi3_pkg::lane_ctl_t        out_ctl
);

	logic [mi3_pkg::DET_STAGES-1:0] v_q;
	logic [mi3_pkg::DET_STAGES:0]   rdy;

	logic signed [mi3_pkg::COF_W-1:0] ph_s1 [mi3_pkg::ROW_N];
	logic signed [mi3_pkg::PL_W-1:0]  pl_s1 [mi3_pkg::ROW_N];
	mi3_pkg::cof_vec_t                cof_s1;
	logic signed [mi3_pkg::DET_W-1:0] t_s2 [mi3_pkg::ROW_N];
	mi3_pkg::cof_vec_t                cof_s2;
	logic signed [mi3_pkg::DET_W-1:0] d_s3;
	mi3_pkg::mag_vec_t                cmag_s3;
	logic [mi3_pkg::N_ELEM-1:0]       csgn_s3;
	mi3_pkg::det_mag_t                dmag_s4;
	logic                             dneg_s4;
	mi3_pkg::mag_vec_t                cmag_s4;
	logic [mi3_pkg::N_ELEM-1:0]       csgn_s4;
	mi3_pkg::det_mag_t                dmag_s5;
	mi3_pkg::mag_vec_t                cmag_s5;
	mi3_pkg::lane_ctl_t               ctl_s5;

	mi3_pkg::det_mag_t thr_ext;

	assign thr_ext = mi3_pkg::DET_W'({thr, {mi3_pkg::THR_SHIFT{1'b0}}});

	always_comb begin
		rdy[mi3_pkg::DET_STAGES] = out_ready;
		for (int s = mi3_pkg::DET_STAGES - 1; s >= 0; s--) begin
			rdy[s] = !v_q[s] || rdy[s+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int s = 1; s < mi3_pkg::DET_STAGES; s++) begin
				if (rdy[s]) begin
					v_q[s] <= v_q[s-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			cof_s1 <= in_cof;
			for (int k = 0; k < mi3_pkg::ROW_N; k++) begin
				ph_s1[k] <= $signed(in_row[k])
					* $signed(in_cof[mi3_pkg::DET_COF[k]][mi3_pkg::COF_W-1:mi3_pkg::HALF_W]);
				pl_s1[k] <= $signed(in_row[k])
					* $signed({1'b0, in_cof[mi3_pkg::DET_COF[k]][mi3_pkg::HALF_W-1:0]});
			end
		end
		if (rdy[1]) begin
			cof_s2 <= cof_s1;
			for (int k = 0; k < mi3_pkg::ROW_N; k++) begin
				t_s2[k] <= (mi3_pkg::DET_W'(ph_s1[k]) <<< mi3_pkg::HALF_W)
					+ mi3_pkg::DET_W'(pl_s1[k]);
			end
		end
		if (rdy[2]) begin
			d_s3 <= t_s2[0] + t_s2[1] + t_s2[2];
			for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
				csgn_s3[i] <= cof_s2[i][mi3_pkg::COF_W-1];
				cmag_s3[i] <= cof_s2[i][mi3_pkg::COF_W-1] ? mi3_pkg::mag_t'(-cof_s2[i])
					: mi3_pkg::mag_t'(cof_s2[i]);
			end
		end
		if (rdy[3]) begin
			dneg_s4 <= d_s3[mi3_pkg::DET_W-1];
			dmag_s4 <= d_s3[mi3_pkg::DET_W-1] ? mi3_pkg::det_mag_t'(-d_s3)
				: mi3_pkg::det_mag_t'(d_s3);
			cmag_s4 <= cmag_s3;
			csgn_s4 <= csgn_s3;
		end
		if (rdy[4]) begin
			dmag_s5         <= dmag_s4;
			cmag_s5         <= cmag_s4;
			ctl_s5.singular <= (dmag_s4 < thr_ext) || (dmag_s4 == '0);
			for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
				ctl_s5.big[i] <= mi3_pkg::DET_W'(cmag_s4[i]) >= dmag_s4;
				ctl_s5.neg[i] <= csgn_s4[i] ^ dneg_s4;
			end
		end
	end

	assign out_valid = v_q[mi3_pkg::DET_STAGES-1];
	assign out_den   = dmag_s5;
	assign out_cmag  = cmag_s5;
	assign out_ctl   = ctl_s5;

endmodule

>>> rtl/core/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// nine-lane restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module mi3_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mi3_pkg::det_mag_t  in_den,
	input  mi3_pkg::mag_vec_t  in_cmag,
	input  mi3_pkg::lane_ctl_t in_ctl,
	output logic               out_valid,
	input  logic               out_ready,
	output mi3_pkg::quo_vec_t  out_quo,
	output mi3_pkg::lane_ctl_t out_ctl
);

	logic [mi3_pkg::DIV_STAGES-1:0] v_q;
	logic [mi3_pkg::DIV_STAGES:0]   rdy;

	logic [mi3_pkg::REM_W-1:0] rem_s    [mi3_pkg::DIV_STAGES][mi3_pkg::N_ELEM];
	mi3_pkg::quo_t             quo_s    [mi3_pkg::DIV_STAGES][mi3_pkg::N_ELEM];
	mi3_pkg::det_mag_t         den_s    [mi3_pkg::DIV_STAGES];
	mi3_pkg::lane_ctl_t        ctl_s    [mi3_pkg::DIV_STAGES];

	logic [mi3_pkg::REM_W-1:0] shl_c    [mi3_pkg::DIV_STAGES][mi3_pkg::N_ELEM];
	logic [mi3_pkg::REM_W-1:0] diff_c   [mi3_pkg::DIV_STAGES][mi3_pkg::N_ELEM];
	mi3_pkg::quo_t             quo_nx_c [mi3_pkg::DIV_STAGES][mi3_pkg::N_ELEM];
	mi3_pkg::det_mag_t         den_c    [mi3_pkg::DIV_STAGES];
	mi3_pkg::lane_ctl_t        ctl_c    [mi3_pkg::DIV_STAGES];

	always_comb begin
		rdy[mi3_pkg::DIV_STAGES] = out_ready;
		for (int s = mi3_pkg::DIV_STAGES - 1; s >= 0; s--) begin
			rdy[s] = !v_q[s] || rdy[s+1];
		end
	end

	assign in_ready = rdy[0];

	always_comb begin
		den_c[0] = in_den;
		ctl_c[0] = in_ctl;
		for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
			shl_c[0][l]    = {(mi3_pkg::REM_W-1)'(in_cmag[l]), 1'b0};
			diff_c[0][l]   = shl_c[0][l] - {1'b0, in_den};
			quo_nx_c[0][l] = mi3_pkg::QUO_W'(!diff_c[0][l][mi3_pkg::REM_W-1]);
		end
		for (int s = 1; s < mi3_pkg::DIV_STAGES; s++) begin
			den_c[s] = den_s[s-1];
			ctl_c[s] = ctl_s[s-1];
			for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
				shl_c[s][l]    = {rem_s[s-1][l][mi3_pkg::REM_W-2:0], 1'b0};
				diff_c[s][l]   = shl_c[s][l] - {1'b0, den_s[s-1]};
				quo_nx_c[s][l] = {quo_s[s-1][l][mi3_pkg::QUO_W-2:0],
					!diff_c[s][l][mi3_pkg::REM_W-1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int s = 1; s < mi3_pkg::DIV_STAGES; s++) begin
				if (rdy[s]) begin
					v_q[s] <= v_q[s-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < mi3_pkg::DIV_STAGES; s++) begin
			if (rdy[s]) begin
				den_s[s] <= den_c[s];
				ctl_s[s] <= ctl_c[s];
				for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
					rem_s[s][l] <= diff_c[s][l][mi3_pkg::REM_W-1] ? shl_c[s][l] : diff_c[s][l];
					quo_s[s][l] <= quo_nx_c[s][l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
			out_quo[l] = quo_s[mi3_pkg::DIV_STAGES-1][l];
		end
	end

	assign out_valid = v_q[mi3_pkg::DIV_STAGES-1];
	assign out_ctl   = ctl_s[mi3_pkg::DIV_STAGES-1];

endmodule

>>> rtl/core/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// inverse of a 3x3 signed Q16.16 matrix by adjugate over determinant
// ----------------------------------------------------------------------------
// one matrix per input transaction (in_valid/in_ready, elements m00..m22),
// one result per output transaction (out_valid/out_ready, inv00..inv22 with
// singular and overflow flags); results leave in input order
// a matrix passes from input to output register through 2 cofactor stages,
// 5 determinant stages, 32 divider stages (one quotient bit each) and the
// saturating output stage; throughput is one matrix per cycle while out_ready
// is high; every stage holds its own valid bit, so a stalled receiver only
// fills empty stages and in_ready drops once the pipeline is full; a matrix
// with |det| below singular_threshold (or det zero) returns the identity with
// singular set; otherwise saturated elements set overflow; the user writes
// singular_threshold through cfg_wr_en/cfg_wr_data only while idle; the block
// does not enforce it; reset clears all valid bits and sets the threshold to
// one lsb
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [mi3_pkg::THR_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  mi3_pkg::elem_t            m00,
	input  mi3_pkg::elem_t            m01,
	input  mi3_pkg::elem_t            m02,
	input  mi3_pkg::elem_t            m10,
	input  mi3_pkg::elem_t            m11,
	input  mi3_pkg::elem_t            m12,
	input  mi3_pkg::elem_t            m20,
	input  mi3_pkg::elem_t            m21,
	input  mi3_pkg::elem_t            m22,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mi3_pkg::elem_t            inv00,
	output mi3_pkg::elem_t            inv01,
	output mi3_pkg::elem_t            inv02,
	output mi3_pkg::elem_t            inv10,
	output mi3_pkg::elem_t            inv11,
	output mi3_pkg::elem_t            inv12,
	output mi3_pkg::elem_t            inv20,
	output mi3_pkg::elem_t            inv21,
	output mi3_pkg::elem_t            inv22,
	output logic                      singular,
	output logic                      overflow
);

	logic [mi3_pkg::THR_W-1:0] thr_q;

	mi3_pkg::mat_t      in_mat;
	logic               cof_valid;
	logic               cof_ready;
	mi3_pkg::row_t      cof_row;
	mi3_pkg::cof_vec_t  cof_vec;
	logic               det_valid;
	logic               det_ready;
	mi3_pkg::det_mag_t  det_den;
	mi3_pkg::mag_vec_t  det_cmag;
	mi3_pkg::lane_ctl_t det_ctl;
	logic               div_valid;
	logic               div_ready;
	mi3_pkg::quo_vec_t  div_quo;
	mi3_pkg::lane_ctl_t div_ctl;

	mi3_pkg::elem_t             val_c [mi3_pkg::N_ELEM];
	logic [mi3_pkg::N_ELEM-1:0] sat_c;

	mi3_pkg::elem_t inv_q [mi3_pkg::N_ELEM];
	logic           singular_q;
	logic           overflow_q;
	logic           out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mi3_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	assign in_mat = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

	mi3_cofactor u_cofactor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_mat    (in_mat),
		.out_valid (cof_valid),
		.out_ready (cof_ready),
		.out_row   (cof_row),
		.out_cof   (cof_vec)
	);

	mi3_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr       (thr_q),
		.in_valid  (cof_valid),
		.in_ready  (cof_ready),
		.in_row    (cof_row),
		.in_cof    (cof_vec),
		.out_valid (det_valid),
		.out_ready (det_ready),
		.out_den   (det_den),
		.out_cmag  (det_cmag),
		.out_ctl   (det_ctl)
	);

	mi3_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (det_valid),
		.in_ready  (det_ready),
		.in_den    (det_den),
		.in_cmag   (det_cmag),
		.in_ctl    (det_ctl),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_quo   (div_quo),
		.out_ctl   (div_ctl)
	);

	// sign, saturation and identity substitution
	always_comb begin
		for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
			if (div_ctl.neg[l]) begin
				sat_c[l] = div_ctl.big[l] || (div_quo[l] > mi3_pkg::quo_t'(mi3_pkg::NEG_MIN));
				val_c[l] = sat_c[l] ? mi3_pkg::NEG_MIN : mi3_pkg::elem_t'(-div_quo[l]);
			end else begin
				sat_c[l] = div_ctl.big[l] || div_quo[l][mi3_pkg::QUO_W-1];
				val_c[l] = sat_c[l] ? mi3_pkg::POS_MAX : mi3_pkg::elem_t'(div_quo[l]);
			end
			if (div_ctl.singular) begin
				val_c[l] = (l % 4 == 0) ? mi3_pkg::ONE_Q : '0;
			end
		end
	end

	assign div_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ready) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready) begin
			for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
				inv_q[l] <= val_c[l];
			end
			singular_q <= div_ctl.singular;
			overflow_q <= !div_ctl.singular && (|sat_c);
		end
	end

	assign out_valid = out_valid_q;
	assign inv00     = inv_q[0];
	assign inv01     = inv_q[1];
	assign inv02     = inv_q[2];
	assign inv10     = inv_q[3];
	assign inv11     = inv_q[4];
	assign inv12     = inv_q[5];
	assign inv20     = inv_q[6];
	assign inv21     = inv_q[7];
	assign inv22     = inv_q[8];
	assign singular  = singular_q;
	assign overflow  = overflow_q;

endmodule

>>> rtl/core/mi3_checker.sv
// ----------------------------------------------------------------------------
// mi3_checker
// port-level checks of the matrix inverse, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_defines.svh"

module mi3_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input mi3_pkg::elem_t inv00,
	input mi3_pkg::elem_t inv01,
	input mi3_pkg::elem_t inv11,
	input mi3_pkg::elem_t inv22,
	input logic           singular,
	input logic           overflow
);

	`MI3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(inv00) && $stable(singular), "stalled result changed")

	`MI3_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

	`MI3_ASSERT_IMPL(a_sing_no_ovf, out_valid && singular, !overflow, "overflow on singular result")

	`MI3_ASSERT_IMPL(a_sing_identity, out_valid && singular, (inv00 == mi3_pkg::ONE_Q) && (inv11 == mi3_pkg::ONE_Q) && (inv22 == mi3_pkg::ONE_Q) && (inv01 == '0), "singular result not identity")

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (.*);

>>> test/matrix3x3_inverse_tb.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse testbench
// drives 3x3 Q16.16 matrices through the inverse pipeline under random
// sender and receiver idling, predicts every inverse in wide integer
// arithmetic and compares each output transaction field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef mi3_pkg::elem_t mtx_t [9];

typedef struct {
	mi3_pkg::elem_t inv [9];
	logic           singular;
	logic           overflow;
} inv_res_t;

class inverse_scoreboard;
	inv_res_t                  pending [$];
	logic [mi3_pkg::THR_W-1:0] threshold;
	int                        mismatches;
	int                        results;
	int                        singular_seen;
	int                        overflow_seen;

	function new();
		threshold = mi3_pkg::THR_RESET;
		mismatches = 0;
		results = 0;
		singular_seen = 0;
		overflow_seen = 0;
	endfunction

	function inv_res_t predict_inverse(mtx_t m);
		logic signed [127:0] x [9];
		logic signed [127:0] adj [9];
		logic signed [127:0] det;
		logic [127:0]        dmag;
		logic [127:0]        cmag;
		logic [127:0]        q;
		logic                neg;
		inv_res_t            r;
		for (int i = 0; i < 9; i++)
			x[i] = m[i];
		adj[0] = x[4] * x[8] - x[5] * x[7];
		adj[1] = x[7] * x[2] - x[8] * x[1];
		adj[2] = x[1] * x[5] - x[2] * x[4];
		adj[3] = x[5] * x[6] - x[3] * x[8];
		adj[4] = x[8] * x[0] - x[6] * x[2];
		adj[5] = x[2] * x[3] - x[0] * x[5];
		adj[6] = x[3] * x[7] - x[4] * x[6];
		adj[7] = x[6] * x[1] - x[7] * x[0];
		adj[8] = x[0] * x[4] - x[1] * x[3];
		det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
		dmag = det < 0 ? -det : det;
		r.overflow = 0;
		if (dmag == 0 || dmag < (128'(threshold) << mi3_pkg::THR_SHIFT)) begin
			for (int i = 0; i < 9; i++)
				r.inv[i] = (i % 4 == 0) ? mi3_pkg::ONE_Q : '0;
			r.singular = 1;
			return r;
		end
		r.singular = 0;
		for (int i = 0; i < 9; i++) begin
			cmag = adj[i] < 0 ? -adj[i] : adj[i];
			neg = (adj[i] < 0) != (det < 0);
			q = (cmag << 32) / dmag;
			if (!neg && q > 128'h7fff_ffff) begin
				r.inv[i] = mi3_pkg::POS_MAX;
				r.overflow = 1;
			end else if (neg && q > 128'h8000_0000) begin
				r.inv[i] = mi3_pkg::NEG_MIN;
				r.overflow = 1;
			end else begin
				r.inv[i] = neg ? -q[31:0] : q[31:0];
			end
		end
		return r;
	endfunction

	function void note_matrix(mtx_t m);
		pending.push_back(predict_inverse(m));
	endfunction

	function void check_inverse(inv_res_t act);
		inv_res_t exp_r;
		logic     bad;
		results++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: output transaction with nothing pending");
			return;
		end
		exp_r = pending.pop_front();
		bad = act.singular !== exp_r.singular || act.overflow !== exp_r.overflow;
		for (int i = 0; i < 9; i++)
			if (act.inv[i] !== exp_r.inv[i])
				bad = 1;
		if (exp_r.singular)
			singular_seen++;
		if (exp_r.overflow)
			overflow_seen++;
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: result %0d mismatch", results);
				for (int i = 0; i < 9; i++)
					$display("  inv[%0d] exp %08h got %08h", i, exp_r.inv[i], act.inv[i]);
				$display("  singular exp %b got %b, overflow exp %b got %b",
					exp_r.singular, act.singular, exp_r.overflow, act.overflow);
			end
		end
	endfunction
endclass

module matrix3x3_inverse_tb;

	logic                      clk = 0;
	logic                      arst_n;
	logic                      cfg_wr_en = 0;
	logic [mi3_pkg::THR_W-1:0] cfg_wr_data = '0;
	logic                      in_valid = 0;
	logic                      in_ready;
	mi3_pkg::elem_t            m00 = '0, m01 = '0, m02 = '0;
	mi3_pkg::elem_t            m10 = '0, m11 = '0, m12 = '0;
	mi3_pkg::elem_t            m20 = '0, m21 = '0, m22 = '0;
	logic                      out_valid;
	logic                      out_ready = 0;
	mi3_pkg::elem_t            inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
	logic                      singular;
	logic                      overflow;

	inverse_scoreboard sb = new();
	int                tx_idle_pct = 0;
	int                rx_idle_pct = 0;
	logic              stall_req = 0;
	logic              stall_ack = 0;
	int                stall_cnt = 0;
	int                sent = 0;

	matrix3x3_inverse i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv00(inv00), .inv01(inv01), .inv02(inv02),
		.inv10(inv10), .inv11(inv11), .inv12(inv12),
		.inv20(inv20), .inv21(inv21), .inv22(inv22),
		.singular(singular), .overflow(overflow)
	);

	always #10 clk = ~clk;

	// receiver with a long hold-off on request
	always @(posedge clk) begin
		if (stall_req != stall_ack) begin
			stall_ack <= stall_req;
			stall_cnt <= 150;
			out_ready <= 0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_ready <= 0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		mtx_t     m;
		inv_res_t r;
		if (in_valid && in_ready) begin
			m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			sb.note_matrix(m);
		end
		if (out_valid && out_ready) begin
			r.inv = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
			r.singular = singular;
			r.overflow = overflow;
			sb.check_inverse(r);
		end
	end

	task automatic send_matrix(mtx_t m);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_threshold(logic [mi3_pkg::THR_W-1:0] thr);
		cfg_wr_en <= 1;
		cfg_wr_data <= thr;
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.threshold = thr;
	endtask

	function automatic mi3_pkg::elem_t rand_elem(int kind);
		case (kind)
			0: return mi3_pkg::elem_t'($urandom);
			1: return mi3_pkg::elem_t'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
			2: return mi3_pkg::elem_t'($urandom_range(32'h0000_0400)) - 32'sh0000_0200;
			default: return mi3_pkg::elem_t'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	task automatic send_random(int n);
		mtx_t m;
		int   kind;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(4);
			for (int i = 0; i < 9; i++)
				m[i] = rand_elem(kind == 4 ? $urandom_range(3) : kind);
			if ($urandom_range(9) == 0) begin
				for (int i = 0; i < 3; i++)
					m[6 + i] = m[3 + i];
			end
			send_matrix(m);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed matrices at the reset threshold
		send_matrix('{mi3_pkg::ONE_Q, 0, 0, 0, mi3_pkg::ONE_Q, 0, 0, 0, mi3_pkg::ONE_Q});
		send_matrix('{default: 0});
		send_matrix('{default: mi3_pkg::POS_MAX});
		send_matrix('{mi3_pkg::POS_MAX, 0, 0, 0, mi3_pkg::POS_MAX, 0, 0, 0,
			mi3_pkg::POS_MAX});
		send_matrix('{mi3_pkg::NEG_MIN, 0, 0, 0, mi3_pkg::NEG_MIN, 0, 0, 0,
			mi3_pkg::NEG_MIN});
		send_matrix('{mi3_pkg::NEG_MIN, mi3_pkg::POS_MAX, 0, 0, mi3_pkg::NEG_MIN,
			mi3_pkg::POS_MAX, mi3_pkg::POS_MAX, 0, mi3_pkg::NEG_MIN});
		send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
		send_matrix('{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100});
		send_matrix('{-mi3_pkg::ONE_Q, 0, 0, 0, mi3_pkg::ONE_Q, 0, 0, 0, mi3_pkg::ONE_Q});
		send_matrix('{2 * mi3_pkg::ONE_Q, mi3_pkg::ONE_Q, 0, mi3_pkg::ONE_Q,
			2 * mi3_pkg::ONE_Q, mi3_pkg::ONE_Q, 0, mi3_pkg::ONE_Q, 2 * mi3_pkg::ONE_Q});
		send_matrix('{mi3_pkg::ONE_Q, 2 * mi3_pkg::ONE_Q, 3 * mi3_pkg::ONE_Q,
			4 * mi3_pkg::ONE_Q, 5 * mi3_pkg::ONE_Q, 6 * mi3_pkg::ONE_Q,
			7 * mi3_pkg::ONE_Q, 8 * mi3_pkg::ONE_Q, 9 * mi3_pkg::ONE_Q});
		send_matrix('{32'sh0, mi3_pkg::ONE_Q, 0, mi3_pkg::ONE_Q, 0, 0, 0, 0,
			-mi3_pkg::ONE_Q});
		send_matrix('{mi3_pkg::NEG_MIN, mi3_pkg::NEG_MIN, mi3_pkg::NEG_MIN,
			mi3_pkg::POS_MAX, 1, 0, -1, mi3_pkg::POS_MAX, mi3_pkg::NEG_MIN});
		send_matrix('{32'sh4000_0000, 0, 0, 0, 32'sh4000_0000, 0, 0, 0, 32'sh0000_0001});
		drain();

		// threshold zero, then the largest threshold
		write_threshold(0);
		send_matrix('{default: 0});
		send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
		send_matrix('{32'sh10, 0, 0, 0, 32'sh10, 0, 0, 0, 32'sh10});
		drain();
		write_threshold(16'hffff);
		send_matrix('{mi3_pkg::ONE_Q, 0, 0, 0, mi3_pkg::ONE_Q, 0, 0, 0, mi3_pkg::ONE_Q});
		send_matrix('{mi3_pkg::ONE_Q - 1, 0, 0, 0, mi3_pkg::ONE_Q, 0, 0, 0,
			mi3_pkg::ONE_Q});
		send_matrix('{32'sh0000_ffff, 0, 0, 0, 32'sh0000_ffff, 0, 0, 0, 32'sh0000_ffff});
		drain();

		write_threshold(mi3_pkg::THR_RESET);
		tx_idle_pct = 35;
		rx_idle_pct = 73;
		send_random(150);

		// long receiver hold-off while matrices keep coming
		stall_req <= ~stall_req;
		tx_idle_pct = 0;
		send_random(60);
		drain();

		write_threshold(16'($urandom));
		tx_idle_pct = 73;
		rx_idle_pct = 35;
		send_random(120);
		drain();

		write_threshold(16'($urandom_range(16)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(120);
		drain();

		$display("run: %0d matrices, %0d results, %0d singular, %0d saturated",
			sent, sb.results, sb.singular_seen, sb.overflow_seen);
		$display("thresholds 0, 1, 65535 and random; idle mixes 35/73, 73/35, none");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout, %0d results still pending", sb.pending.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> matrix3x3_inverse.f
+incdir+rtl/core
rtl/core/mi3_pkg.sv
rtl/core/mi3_cofactor.sv
rtl/core/mi3_det.sv
rtl/core/mi3_div.sv
rtl/core/matrix3x3_inverse.sv
rtl/core/mi3_checker.sv
test/matrix3x3_inverse_tb.sv
